// ===== rtl/core/etu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etu_pkg
// Widths, calendar constants, reciprocal multipliers and small tables for the
// epoch seconds to UTC digits converter.
// ----------------------------------------------------------------------------
package etu_pkg;

  localparam int unsigned EpochW   = 38;
  localparam int unsigned YearW    = 14;
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned HourW    = 5;
  localparam int unsigned MinW     = 6;
  localparam int unsigned SecW     = 6;
  localparam int unsigned DateBcdW = 32;
  localparam int unsigned TimeBcdW = 22;

  localparam logic [EpochW-1:0] LastValidSec = 38'd253402300799;

  localparam int unsigned DayDiv    = 675;
  localparam int unsigned DayShift  = 31;
  localparam logic [21:0] DayMul    = 22'((64'd1 << DayShift) / DayDiv);

  localparam int unsigned EpochShift = 719468;
  localparam int unsigned EraDays    = 146097;
  localparam int unsigned EraShift   = 22;
  localparam logic [4:0]  EraMul     = 5'((64'd1 << EraShift) / EraDays);
  localparam int unsigned EraYears   = 400;

  localparam int unsigned HourSecs  = 3600;
  localparam int unsigned HourShift = 17;
  localparam logic [5:0]  HourMul   = 6'((64'd1 << HourShift) / HourSecs);

  localparam int unsigned MinSecs   = 60;
  localparam int unsigned MinShift  = 12;
  localparam logic [6:0]  MinMul    = 7'((64'd1 << MinShift) / MinSecs);

  localparam int unsigned LeapDiv   = 1460;
  localparam int unsigned LeapShift = 18;
  localparam logic [7:0]  LeapMul   = 8'((64'd1 << LeapShift) / LeapDiv);

  localparam int unsigned CentDays   = 36524;
  localparam int unsigned LastEraDay = 146096;

  localparam int unsigned YearDays  = 365;
  localparam int unsigned YearShift = 18;
  localparam logic [9:0]  YearMul   = 10'((64'd1 << YearShift) / YearDays);

  localparam int unsigned MonDiv    = 153;
  localparam int unsigned MonShift  = 12;
  localparam logic [4:0]  MonMul    = 5'((64'd1 << MonShift) / MonDiv);

  localparam int unsigned HundredDiv   = 100;
  localparam int unsigned HundredShift = 14;
  localparam logic [7:0]  HundredMul   = 8'((64'd1 << HundredShift) / HundredDiv);

  // two BCD digits of a value below one hundred
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  tens;
    logic [3:0]  ones;
    p    = 15'(v) * 15'(205);
    tens = p[14:11];
    ones = 4'(v - 7'(tens) * 7'(10));
    return {tens, ones};
  endfunction

  // first day of each March-based month within the year
  function automatic logic [8:0] mp_days(input logic [4:0] mp);
    logic [8:0] r;
    case (mp)
      5'd0:    r = 9'd0;
      5'd1:    r = 9'd31;
      5'd2:    r = 9'd61;
      5'd3:    r = 9'd92;
      5'd4:    r = 9'd122;
      5'd5:    r = 9'd153;
      5'd6:    r = 9'd184;
      5'd7:    r = 9'd214;
      5'd8:    r = 9'd245;
      5'd9:    r = 9'd275;
      5'd10:   r = 9'd306;
      5'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/etu_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etu_in_if
// Request channel carrying one epoch timestamp in seconds.
// ----------------------------------------------------------------------------
interface etu_in_if import etu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/etu_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// etu_out_if
// Result channel carrying the civil date, time of day and their BCD digits.
// ----------------------------------------------------------------------------
interface etu_out_if import etu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YearW-1:0]    year;
  logic [MonthW-1:0]   month;
  logic [DayW-1:0]     day_of_month;
  logic [HourW-1:0]    hour;
  logic [MinW-1:0]     minute;
  logic [SecW-1:0]     second;
  logic [DateBcdW-1:0] date_bcd;
  logic [TimeBcdW-1:0] time_bcd;
  logic                out_of_range;

  modport source (
    output valid, output year, output month, output day_of_month, output hour,
    output minute, output second, output date_bcd, output time_bcd,
    output out_of_range, input ready
  );
  modport sink (
    input valid, input year, input month, input day_of_month, input hour,
    input minute, input second, input date_bcd, input time_bcd,
    input out_of_range, output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/epoch_seconds_to_utc_digits.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_digits
// Unix seconds to proleptic Gregorian UTC date, time of day and BCD digits.
// ----------------------------------------------------------------------------
// A fourteen-stage pipeline (stages 0 to 13) that takes a new request every
// cycle unless a stalled result holds it. Each division by a calendar
// constant other than the century counts, which use comparisons, is a
// multiplication by a truncated reciprocal in one stage followed by a
// compare-and-correct step on the quotient in the next. Timestamps past
// 9999-12-31T23:59:59 return out_of_range with all other fields zero. A
// stalled result holds in the last stage; each stage keeps its request until
// the one after it has room.
module epoch_seconds_to_utc_digits import etu_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  etu_in_if.sink     in_i,
  etu_out_if.source  out_o
);

  localparam int unsigned NumStg = 14;

  logic [NumStg-1:0] vld_q;
  logic [NumStg:0]   rdy;
  logic [NumStg-1:0] up_vld;
  logic [NumStg-1:0] ld;

  always_comb begin
    rdy[NumStg] = out_o.ready;
    for (int k = NumStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    up_vld = {vld_q[NumStg-2:0], in_i.valid};
    ld     = rdy[NumStg-1:0] & up_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= up_vld[k];
        end
      end
    end
  end

  assign in_i.ready  = rdy[0];
  assign out_o.valid = vld_q[NumStg-1];

  // stage 0
  logic [30:0] s0_x_d, s0_x_q;
  logic [6:0]  s0_lo_d, s0_lo_q;
  logic        s0_oor_d, s0_oor_q;
  logic [52:0] s0_p_d, s0_p_q;
  // stage 1
  logic [21:0] s1_days_d, s1_days_q;
  logic [16:0] s1_tod_d, s1_tod_q;
  logic        s1_oor_q;
  // stage 2
  logic [21:0] s2_z_d, s2_z_q;
  logic [26:0] s2_pe_d, s2_pe_q;
  logic [22:0] s2_ph_d, s2_ph_q;
  logic [16:0] s2_tod_q;
  logic        s2_oor_q;
  // stage 3
  logic [4:0]  s3_era_d, s3_era_q;
  logic [17:0] s3_doe_d, s3_doe_q;
  logic [4:0]  s3_hh_d, s3_hh_q;
  logic [11:0] s3_remh_d, s3_remh_q;
  logic        s3_oor_q;
  // stage 4
  logic [25:0] s4_pl_d, s4_pl_q;
  logic [2:0]  s4_cc_d, s4_cc_q;
  logic        s4_cl_d, s4_cl_q;
  logic [18:0] s4_pm_d, s4_pm_q;
  logic [4:0]  s4_era_q;
  logic [17:0] s4_doe_q;
  logic [4:0]  s4_hh_q;
  logic [11:0] s4_remh_q;
  logic        s4_oor_q;
  // stage 5
  logic [17:0] s5_n_d, s5_n_q;
  logic [5:0]  s5_mi_d, s5_mi_q;
  logic [5:0]  s5_ss_d, s5_ss_q;
  logic [4:0]  s5_era_q;
  logic [17:0] s5_doe_q;
  logic [4:0]  s5_hh_q;
  logic        s5_oor_q;
  // stage 6
  logic [27:0] s6_p_d, s6_p_q;
  logic [17:0] s6_n_q;
  logic [4:0]  s6_era_q;
  logic [17:0] s6_doe_q;
  logic [4:0]  s6_hh_q;
  logic [5:0]  s6_mi_q, s6_ss_q;
  logic        s6_oor_q;
  // stage 7
  logic [8:0]  s7_yoe_d, s7_yoe_q;
  logic [4:0]  s7_era_q;
  logic [17:0] s7_doe_q;
  logic [4:0]  s7_hh_q;
  logic [5:0]  s7_mi_q, s7_ss_q;
  logic        s7_oor_q;
  // stage 8
  logic [8:0]  s8_doy_d, s8_doy_q;
  logic [13:0] s8_y_d, s8_y_q;
  logic [4:0]  s8_hh_q;
  logic [5:0]  s8_mi_q, s8_ss_q;
  logic        s8_oor_q;
  // stage 9
  logic [11:0] s9_num_d, s9_num_q;
  logic [16:0] s9_p_d, s9_p_q;
  logic [8:0]  s9_doy_q;
  logic [13:0] s9_y_q;
  logic [4:0]  s9_hh_q;
  logic [5:0]  s9_mi_q, s9_ss_q;
  logic        s9_oor_q;
  // stage 10
  logic [13:0] s10_y_d, s10_y_q;
  logic [3:0]  s10_m_d, s10_m_q;
  logic [4:0]  s10_d_d, s10_d_q;
  logic [4:0]  s10_hh_q;
  logic [5:0]  s10_mi_q, s10_ss_q;
  logic        s10_oor_q;
  // stage 11
  logic [21:0] s11_p_d, s11_p_q;
  logic [15:0] s11_md_d, s11_md_q;
  logic [21:0] s11_t_d, s11_t_q;
  logic [13:0] s11_y_q;
  logic [3:0]  s11_m_q;
  logic [4:0]  s11_d_q;
  logic [4:0]  s11_hh_q;
  logic [5:0]  s11_mi_q, s11_ss_q;
  logic        s11_oor_q;
  // stage 12
  logic [6:0]  s12_hi_d, s12_hi_q;
  logic [6:0]  s12_lo_d, s12_lo_q;
  logic [15:0] s12_md_q;
  logic [21:0] s12_t_q;
  logic [13:0] s12_y_q;
  logic [3:0]  s12_m_q;
  logic [4:0]  s12_d_q;
  logic [4:0]  s12_hh_q;
  logic [5:0]  s12_mi_q, s12_ss_q;
  logic        s12_oor_q;
  // stage 13
  logic [YearW-1:0]    s13_year_d, s13_year_q;
  logic [MonthW-1:0]   s13_month_d, s13_month_q;
  logic [DayW-1:0]     s13_dom_d, s13_dom_q;
  logic [HourW-1:0]    s13_hour_d, s13_hour_q;
  logic [MinW-1:0]     s13_min_d, s13_min_q;
  logic [SecW-1:0]     s13_sec_d, s13_sec_q;
  logic [DateBcdW-1:0] s13_date_d, s13_date_q;
  logic [TimeBcdW-1:0] s13_time_d, s13_time_q;
  logic                s13_oor_q;

  always_comb begin
    logic [21:0] q_day;
    logic [10:0] r_day;
    logic [4:0]  q_era;
    logic [18:0] r_era;
    logic [5:0]  q_hr;
    logic [12:0] r_hr;
    logic [7:0]  q_lp;
    logic [11:0] r_lp;
    logic [6:0]  q_mi;
    logic [6:0]  r_mi;
    logic [9:0]  q_yr;
    logic [9:0]  r_yr;
    logic [1:0]  c100;
    logic [17:0] sub;
    logic [4:0]  q_mp;
    logic [8:0]  r_mp;
    logic [3:0]  m_t;
    logic [7:0]  q_hu;
    logic [7:0]  r_hu;
    logic [7:0]  hh_bcd;

    s0_x_d   = in_i.epoch_seconds[37:7];
    s0_lo_d  = in_i.epoch_seconds[6:0];
    s0_oor_d = in_i.epoch_seconds > LastValidSec;
    s0_p_d   = 53'(s0_x_d) * 53'(DayMul);

    q_day = s0_p_q[52:31];
    r_day = 11'(s0_x_q - 31'(q_day) * 31'(DayDiv));
    if (r_day >= 11'(DayDiv)) begin
      q_day = q_day + 22'd1;
      r_day = r_day - 11'(DayDiv);
    end
    s1_days_d = q_day;
    s1_tod_d  = {r_day[9:0], s0_lo_q};

    s2_z_d  = s1_days_q + 22'(EpochShift);
    s2_pe_d = 27'(s2_z_d) * 27'(EraMul);
    s2_ph_d = 23'(s1_tod_q) * 23'(HourMul);

    q_era = s2_pe_q[26:22];
    r_era = 19'(s2_z_q - 22'(q_era) * 22'(EraDays));
    if (r_era >= 19'(EraDays)) begin
      q_era = q_era + 5'd1;
      r_era = r_era - 19'(EraDays);
    end
    s3_era_d = q_era;
    s3_doe_d = r_era[17:0];
    q_hr = s2_ph_q[22:17];
    r_hr = 13'(s2_tod_q - 17'(q_hr) * 17'(HourSecs));
    if (r_hr >= 13'(HourSecs)) begin
      q_hr = q_hr + 6'd1;
      r_hr = r_hr - 13'(HourSecs);
    end
    s3_hh_d   = q_hr[4:0];
    s3_remh_d = r_hr[11:0];

    s4_pl_d = 26'(s3_doe_q) * 26'(LeapMul);
    s4_cc_d = {2'b0, s3_doe_q >= 18'(CentDays)}
            + {2'b0, s3_doe_q >= 18'(2 * CentDays)}
            + {2'b0, s3_doe_q >= 18'(3 * CentDays)}
            + {2'b0, s3_doe_q >= 18'(LastEraDay)};
    s4_cl_d = s3_doe_q == 18'(LastEraDay);
    s4_pm_d = 19'(s3_remh_q) * 19'(MinMul);

    q_lp = s4_pl_q[25:18];
    r_lp = 12'(s4_doe_q - 18'(q_lp) * 18'(LeapDiv));
    if (r_lp >= 12'(LeapDiv)) begin
      q_lp = q_lp + 8'd1;
    end
    s5_n_d = s4_doe_q - 18'(q_lp) + 18'(s4_cc_q) - 18'(s4_cl_q);
    q_mi = s4_pm_q[18:12];
    r_mi = 7'(s4_remh_q - 12'(q_mi) * 12'(MinSecs));
    if (r_mi >= 7'(MinSecs)) begin
      q_mi = q_mi + 7'd1;
      r_mi = r_mi - 7'(MinSecs);
    end
    s5_mi_d = q_mi[5:0];
    s5_ss_d = r_mi[5:0];

    s6_p_d = 28'(s5_n_q) * 28'(YearMul);

    q_yr = s6_p_q[27:18];
    r_yr = 10'(s6_n_q - 18'(q_yr) * 18'(YearDays));
    if (r_yr >= 10'(YearDays)) begin
      q_yr = q_yr + 10'd1;
    end
    s7_yoe_d = q_yr[8:0];

    c100 = {1'b0, s7_yoe_q >= 9'd100} + {1'b0, s7_yoe_q >= 9'd200}
         + {1'b0, s7_yoe_q >= 9'd300};
    sub = 18'(s7_yoe_q) * 18'(YearDays) + 18'(s7_yoe_q[8:2]) - 18'(c100);
    s8_doy_d = 9'(s7_doe_q - sub);
    s8_y_d   = 14'(s7_yoe_q) + 14'(s7_era_q) * 14'(EraYears);

    s9_num_d = 12'(s8_doy_q) * 12'(5) + 12'd2;
    s9_p_d   = 17'(s9_num_d) * 17'(MonMul);

    q_mp = s9_p_q[16:12];
    r_mp = 9'(s9_num_q - 12'(q_mp) * 12'(MonDiv));
    if (r_mp >= 9'(MonDiv)) begin
      q_mp = q_mp + 5'd1;
    end
    s10_d_d = 5'(s9_doy_q - mp_days(q_mp) + 9'd1);
    m_t     = (q_mp < 5'd10) ? 4'(q_mp + 5'd3) : 4'(q_mp - 5'd9);
    s10_m_d = m_t;
    s10_y_d = (m_t <= 4'd2) ? s9_y_q + 14'd1 : s9_y_q;

    s11_p_d  = 22'(s10_y_q) * 22'(HundredMul);
    s11_md_d = {bcd2(7'(s10_m_q)), bcd2(7'(s10_d_q))};
    hh_bcd   = bcd2(7'(s10_hh_q));
    s11_t_d  = {hh_bcd[5:0], bcd2(7'(s10_mi_q)), bcd2(7'(s10_ss_q))};

    q_hu = s11_p_q[21:14];
    r_hu = 8'(s11_y_q - 14'(q_hu) * 14'(HundredDiv));
    if (r_hu >= 8'(HundredDiv)) begin
      q_hu = q_hu + 8'd1;
      r_hu = r_hu - 8'(HundredDiv);
    end
    s12_hi_d = q_hu[6:0];
    s12_lo_d = r_hu[6:0];

    if (s12_oor_q) begin
      s13_year_d  = '0;
      s13_month_d = '0;
      s13_dom_d   = '0;
      s13_hour_d  = '0;
      s13_min_d   = '0;
      s13_sec_d   = '0;
      s13_date_d  = '0;
      s13_time_d  = '0;
    end else begin
      s13_year_d  = s12_y_q;
      s13_month_d = s12_m_q;
      s13_dom_d   = s12_d_q;
      s13_hour_d  = s12_hh_q;
      s13_min_d   = s12_mi_q;
      s13_sec_d   = s12_ss_q;
      s13_date_d  = {bcd2(s12_hi_q), bcd2(s12_lo_q), s12_md_q};
      s13_time_d  = s12_t_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s0_x_q   <= s0_x_d;
      s0_lo_q  <= s0_lo_d;
      s0_oor_q <= s0_oor_d;
      s0_p_q   <= s0_p_d;
    end
    if (ld[1]) begin
      s1_days_q <= s1_days_d;
      s1_tod_q  <= s1_tod_d;
      s1_oor_q  <= s0_oor_q;
    end
    if (ld[2]) begin
      s2_z_q   <= s2_z_d;
      s2_pe_q  <= s2_pe_d;
      s2_ph_q  <= s2_ph_d;
      s2_tod_q <= s1_tod_q;
      s2_oor_q <= s1_oor_q;
    end
    if (ld[3]) begin
      s3_era_q  <= s3_era_d;
      s3_doe_q  <= s3_doe_d;
      s3_hh_q   <= s3_hh_d;
      s3_remh_q <= s3_remh_d;
      s3_oor_q  <= s2_oor_q;
    end
    if (ld[4]) begin
      s4_pl_q   <= s4_pl_d;
      s4_cc_q   <= s4_cc_d;
      s4_cl_q   <= s4_cl_d;
      s4_pm_q   <= s4_pm_d;
      s4_era_q  <= s3_era_q;
      s4_doe_q  <= s3_doe_q;
      s4_hh_q   <= s3_hh_q;
      s4_remh_q <= s3_remh_q;
      s4_oor_q  <= s3_oor_q;
    end
    if (ld[5]) begin
      s5_n_q   <= s5_n_d;
      s5_mi_q  <= s5_mi_d;
      s5_ss_q  <= s5_ss_d;
      s5_era_q <= s4_era_q;
      s5_doe_q <= s4_doe_q;
      s5_hh_q  <= s4_hh_q;
      s5_oor_q <= s4_oor_q;
    end
    if (ld[6]) begin
      s6_p_q   <= s6_p_d;
      s6_n_q   <= s5_n_q;
      s6_era_q <= s5_era_q;
      s6_doe_q <= s5_doe_q;
      s6_hh_q  <= s5_hh_q;
      s6_mi_q  <= s5_mi_q;
      s6_ss_q  <= s5_ss_q;
      s6_oor_q <= s5_oor_q;
    end
    if (ld[7]) begin
      s7_yoe_q <= s7_yoe_d;
      s7_era_q <= s6_era_q;
      s7_doe_q <= s6_doe_q;
      s7_hh_q  <= s6_hh_q;
      s7_mi_q  <= s6_mi_q;
      s7_ss_q  <= s6_ss_q;
      s7_oor_q <= s6_oor_q;
    end
    if (ld[8]) begin
      s8_doy_q <= s8_doy_d;
      s8_y_q   <= s8_y_d;
      s8_hh_q  <= s7_hh_q;
      s8_mi_q  <= s7_mi_q;
      s8_ss_q  <= s7_ss_q;
      s8_oor_q <= s7_oor_q;
    end
    if (ld[9]) begin
      s9_num_q <= s9_num_d;
      s9_p_q   <= s9_p_d;
      s9_doy_q <= s8_doy_q;
      s9_y_q   <= s8_y_q;
      s9_hh_q  <= s8_hh_q;
      s9_mi_q  <= s8_mi_q;
      s9_ss_q  <= s8_ss_q;
      s9_oor_q <= s8_oor_q;
    end
    if (ld[10]) begin
      s10_y_q   <= s10_y_d;
      s10_m_q   <= s10_m_d;
      s10_d_q   <= s10_d_d;
      s10_hh_q  <= s9_hh_q;
      s10_mi_q  <= s9_mi_q;
      s10_ss_q  <= s9_ss_q;
      s10_oor_q <= s9_oor_q;
    end
    if (ld[11]) begin
      s11_p_q   <= s11_p_d;
      s11_md_q  <= s11_md_d;
      s11_t_q   <= s11_t_d;
      s11_y_q   <= s10_y_q;
      s11_m_q   <= s10_m_q;
      s11_d_q   <= s10_d_q;
      s11_hh_q  <= s10_hh_q;
      s11_mi_q  <= s10_mi_q;
      s11_ss_q  <= s10_ss_q;
      s11_oor_q <= s10_oor_q;
    end
    if (ld[12]) begin
      s12_hi_q  <= s12_hi_d;
      s12_lo_q  <= s12_lo_d;
      s12_md_q  <= s11_md_q;
      s12_t_q   <= s11_t_q;
      s12_y_q   <= s11_y_q;
      s12_m_q   <= s11_m_q;
      s12_d_q   <= s11_d_q;
      s12_hh_q  <= s11_hh_q;
      s12_mi_q  <= s11_mi_q;
      s12_ss_q  <= s11_ss_q;
      s12_oor_q <= s11_oor_q;
    end
    if (ld[13]) begin
      s13_year_q  <= s13_year_d;
      s13_month_q <= s13_month_d;
      s13_dom_q   <= s13_dom_d;
      s13_hour_q  <= s13_hour_d;
      s13_min_q   <= s13_min_d;
      s13_sec_q   <= s13_sec_d;
      s13_date_q  <= s13_date_d;
      s13_time_q  <= s13_time_d;
      s13_oor_q   <= s12_oor_q;
    end
  end

  assign out_o.year         = s13_year_q;
  assign out_o.month        = s13_month_q;
  assign out_o.day_of_month = s13_dom_q;
  assign out_o.hour         = s13_hour_q;
  assign out_o.minute       = s13_min_q;
  assign out_o.second       = s13_sec_q;
  assign out_o.date_bcd     = s13_date_q;
  assign out_o.time_bcd     = s13_time_q;
  assign out_o.out_of_range = s13_oor_q;

endmodule
`default_nettype wire
